@@ design/sse_pkg.sv @@
// ----------------------------------------------------------------------------
// sse_pkg
// Shared sizes, codes and control types of the searchable stack engine.
// ----------------------------------------------------------------------------
package sse_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		ACT_PUSH    = 3'd0,
		ACT_SEARCH  = 3'd1,
		ACT_EDIT    = 3'd2,
		ACT_DELETE  = 3'd3,
		ACT_DISPLAY = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NOTFOUND = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_FULL     = 3'd3,
		ST_ENTRY    = 3'd4
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_DISP
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic exec;        // run a single-result operation, load output regs
		logic disp_start;  // load display pointer with the top index
		logic disp_step;   // emit the entry at the display pointer
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;
		logic disp_zero;   // display pointer sits at the bottom entry
	} dp_stat_t;

endpackage

@@ design/sse_ctrl.sv @@
// ----------------------------------------------------------------------------
// sse_ctrl
// Sequencer: input acceptance, display walk and output beat valid.
// ----------------------------------------------------------------------------
module sse_ctrl import sse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] action,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_stat_t   stat,
	output dp_cmd_t    cmd
);

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   slot_free;
	logic   acc;
	logic   is_single;
	logic   is_disp;

	assign slot_free = !out_valid_q || out_ready;
	assign acc       = in_valid && in_ready;
	assign is_single = (action == ACT_PUSH) || (action == ACT_SEARCH) ||
	                   (action == ACT_EDIT) || (action == ACT_DELETE) ||
	                   ((action == ACT_DISPLAY) && stat.empty);
	assign is_disp   = (action == ACT_DISPLAY) && !stat.empty;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc && is_disp)
					state_nxt = S_DISP;
			end
			S_DISP: begin
				if (slot_free && stat.disp_zero)
					state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready       = 1'b0;
		cmd.exec       = 1'b0;
		cmd.disp_start = 1'b0;
		cmd.disp_step  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready       = slot_free;
				cmd.exec       = acc && is_single;
				cmd.disp_start = acc && is_disp;
			end
			S_DISP: begin
				cmd.disp_step = slot_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.exec || cmd.disp_step)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ design/sse_dp.sv @@
// ----------------------------------------------------------------------------
// sse_dp
// Register cells with parallel compare and shift, fill count, display
// pointer and the output beat register.
// ----------------------------------------------------------------------------
module sse_dp import sse_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [2:0]         action,
	input  logic signed [31:0] value,
	input  logic signed [31:0] new_value,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	output logic [2:0]         status,
	output logic signed [31:0] entry_value,
	output logic               last
);

	logic signed [31:0] entries_q [DEPTH];
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   disp_idx_q;
	status_t            status_q;
	logic signed [31:0] entry_value_q;
	logic               last_q;

	logic [DEPTH-1:0]   eq;       // live cell matches the key
	logic [DEPTH-1:0]   above;    // some match sits above this cell
	logic [DEPTH-1:0]   sel;      // match nearest the top
	logic [DEPTH-1:0]   ge;       // at or above the selected cell
	logic signed [31:0] upper [DEPTH];
	logic               full;
	logic               empty;
	logic               found;
	logic               do_push;
	logic               do_edit;
	logic               do_del;
	status_t            res_status;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign found = |eq;

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			assign eq[g]  = (CNT_W'(g) < count_q) && (entries_q[g] == value);
			assign sel[g] = eq[g] && !above[g];

			if (g == DEPTH - 1) begin : g_top
				assign above[g] = 1'b0;
				assign upper[g] = entries_q[g];
			end else begin : g_mid
				assign above[g] = above[g+1] | eq[g+1];
				assign upper[g] = entries_q[g+1];
			end

			if (g == 0) begin : g_bot
				assign ge[g] = sel[g];
			end else begin : g_up
				assign ge[g] = ge[g-1] | sel[g];
			end

			always_ff @(posedge clk) begin
				if (do_push && (count_q == CNT_W'(g)))
					entries_q[g] <= value;
				else if (do_edit && sel[g])
					entries_q[g] <= new_value;
				else if (do_del && ge[g])
					entries_q[g] <= upper[g];
			end
		end
	endgenerate

	// decode of single-result operations
	always_comb begin
		res_status = ST_OK;
		do_push    = 1'b0;
		do_edit    = 1'b0;
		do_del     = 1'b0;
		case (action)
			ACT_PUSH: begin
				if (full)
					res_status = ST_FULL;
				else
					do_push = cmd.exec;
			end
			ACT_SEARCH, ACT_EDIT, ACT_DELETE: begin
				if (empty)
					res_status = ST_EMPTY;
				else if (!found)
					res_status = ST_NOTFOUND;
				else begin
					do_edit = cmd.exec && (action == ACT_EDIT);
					do_del  = cmd.exec && (action == ACT_DELETE);
				end
			end
			ACT_DISPLAY: res_status = ST_EMPTY;
			default:     res_status = ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_push) begin
			count_q <= count_q + CNT_W'(1);
		end else if (do_del) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	logic [CNT_W-1:0] top_idx;
	assign top_idx = count_q - CNT_W'(1);

	always_ff @(posedge clk) begin
		if (cmd.disp_start)
			disp_idx_q <= top_idx[IDX_W-1:0];
		else if (cmd.disp_step)
			disp_idx_q <= disp_idx_q - IDX_W'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q      <= res_status;
			entry_value_q <= '0;
			last_q        <= 1'b1;
		end else if (cmd.disp_step) begin
			status_q      <= ST_ENTRY;
			entry_value_q <= entries_q[disp_idx_q];
			last_q        <= (disp_idx_q == '0);
		end
	end

	assign stat.empty     = empty;
	assign stat.disp_zero = (disp_idx_q == '0);
	assign status         = status_q;
	assign entry_value    = entry_value_q;
	assign last           = last_q;

endmodule

@@ design/searchable_stack_engine.sv @@
// ----------------------------------------------------------------------------
// searchable_stack_engine
// LIFO of signed 32-bit values with search, edit, delete and display.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready) carries action, value, new_value.
//    Output channel (out_valid/out_ready) carries status, entry_value, last.
//  - Push, search, edit, delete and display-of-empty give one output beat,
//    registered in the cycle after acceptance. All cells compare against the
//    key in parallel and delete shifts the cells above the hit down in the
//    same cycle, so these sustain one item per cycle while out_ready is high.
//  - Display of a non-empty stack walks a pointer from top to bottom and
//    emits fill_count beats, one per cycle while out_ready is high; input is
//    held off until the walk issues its final beat (last set).
//  - Action codes 5 to 7 are consumed and give no beat.
//  - A single output register separates the sides: a new item is taken while
//    a finished beat waits, as long as that beat leaves in the same cycle.
//    While the receiver stalls, the beat holds and in_ready stays low.
//  - Reset (arst_n low) empties the stack and drops any pending beat; cell
//    contents are not cleared, only the fill count.
// ----------------------------------------------------------------------------
module searchable_stack_engine import sse_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         action,
	input  logic signed [31:0] value,
	input  logic signed [31:0] new_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic signed [31:0] entry_value,
	output logic               last
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer: acceptance and the display walk
	sse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// cells, fill count and output beat register
	sse_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.action      (action),
		.value       (value),
		.new_value   (new_value),
		.cmd         (cmd),
		.stat        (stat),
		.status      (status),
		.entry_value (entry_value),
		.last        (last)
	);

endmodule
